FILE: design/scd_pkg.sv
// Shared sizes and types of the set-associative cache tag directory.
package scd_pkg;

	// Cache geometry.
	localparam int SETS = 128;
	localparam int WAYS = 8;
	localparam int LINE_BYTES = 64;

	// Field widths derived from the geometry and the 32-bit byte address.
	localparam int ADDR_W = 32;
	localparam int LEN_W = 3;
	localparam int OFF_W = $clog2(LINE_BYTES);
	localparam int SET_W = $clog2(SETS);
	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int LINE_W = ADDR_W - OFF_W;
	localparam int TAG_W = LINE_W - SET_W;

	// Command queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// One classified access waiting for lookup.
	typedef struct packed {
		logic is_write;
		logic crosses;
		logic [LINE_W-1:0] line;
	} cmd_t;

	// Handshake between the command queue and the lookup engine.
	typedef struct packed {
		logic avail;
		cmd_t cmd;
	} queue_head_t;

	// One set of the directory: a valid bit and a tag per way.
	typedef struct packed {
		logic [WAYS-1:0] vld;
		logic [WAYS-1:0][TAG_W-1:0] tag;
	} row_t;

endpackage

FILE: design/scd_front.sv
// Front end: accepts accesses, classifies line crossing and queues them.
module scd_front
	import scd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic mode,
	input  logic [ADDR_W-1:0] address,
	input  logic [LEN_W-1:0] length,
	output queue_head_t head,
	input  logic pop
);

	cmd_t entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic push;
	logic do_pop;
	logic [OFF_W:0] end_sum;
	cmd_t new_cmd;

	// The access crosses the line end when offset plus length passes the line size.
	assign end_sum = {1'b0, address[OFF_W-1:0]} + (OFF_W+1)'(length);
	assign new_cmd.is_write = mode;
	assign new_cmd.crosses = end_sum > (OFF_W+1)'(LINE_BYTES);
	assign new_cmd.line = address[ADDR_W-1:OFF_W];

	assign busy = count_q == QCNT_W'(QUEUE_DEPTH);
	assign push = start && !busy;
	assign do_pop = pop && (count_q != '0);

	assign head.avail = count_q != '0;
	assign head.cmd = entry_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= new_cmd;
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

FILE: design/scd_back.sv
// Back end: looks lines up in the tag memory, allocates on read misses, emits results.
module scd_back
	import scd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  queue_head_t head,
	output logic pop,
	output logic valid,
	output logic hit,
	output logic [WAY_W-1:0] way,
	output logic [SET_W-1:0] set_index,
	output logic allocated,
	output logic [LINE_W-1:0] line_number,
	output logic last
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_CMP = 1'b1;

	logic state_q;
	logic is_write_q;
	logic crosses_q;
	logic second_q;
	logic [LINE_W-1:0] line_q;

	// Tag memory, one row per set, and a written flag per row.
	row_t mem [SETS];
	row_t rdata_s2;
	logic rowv_s2;
	logic [SETS-1:0] row_valid_q;

	logic issue;
	logic [LINE_W-1:0] rd_line;
	logic [SET_W-1:0] rd_set;
	logic [SET_W-1:0] cur_set;
	logic [TAG_W-1:0] cur_tag;
	logic [WAYS-1:0] eff_vld;
	logic [WAYS-1:0] match;
	logic found;
	logic [WAY_W-1:0] hit_way;
	logic [WAY_W-1:0] free_way;
	logic [WAY_W-1:0] res_way;
	logic we;
	logic go_next;
	row_t wdata;

	// Read issue: a new command when idle, or the following line after a crossing hit.
	assign pop = (state_q == ST_IDLE) && head.avail;
	assign issue = pop || go_next;
	assign rd_line = (state_q == ST_IDLE) ? head.cmd.line : line_q + 1'b1;
	assign rd_set = rd_line[SET_W-1:0];

	assign cur_set = line_q[SET_W-1:0];
	assign cur_tag = line_q[LINE_W-1:SET_W];
	assign eff_vld = rowv_s2 ? rdata_s2.vld : '0;

	// Tag compare on every way, then the lowest match and the lowest free way.
	always_comb begin
		match = '0;
		found = 1'b0;
		hit_way = '0;
		free_way = '0;
		for (int w = 0; w < WAYS; w++)
			match[w] = eff_vld[w] && (rdata_s2.tag[w] == cur_tag);
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (match[w]) begin
				found = 1'b1;
				hit_way = WAY_W'(w);
			end
			if (!eff_vld[w])
				free_way = WAY_W'(w);
		end
	end

	assign we = (state_q == ST_CMP) && !found && !is_write_q;
	assign go_next = (state_q == ST_CMP) && found && crosses_q && !second_q;
	assign res_way = found ? hit_way : (we ? free_way : '0);

	// Updated row for an allocation.
	always_comb begin
		wdata = rdata_s2;
		wdata.vld = eff_vld;
		wdata.vld[free_way] = 1'b1;
		wdata.tag[free_way] = cur_tag;
	end

	// Memory write and registered read.
	always_ff @(posedge clk) begin
		if (we)
			mem[cur_set] <= wdata;
		if (issue) begin
			rdata_s2 <= mem[rd_set];
			rowv_s2 <= row_valid_q[rd_set];
		end
	end

	// Row written flags start clear after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			row_valid_q <= '0;
		else if (we)
			row_valid_q[cur_set] <= 1'b1;
	end

	// Lookup sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid <= 1'b0;
		end else begin
			valid <= state_q == ST_CMP;
			case (state_q)
				ST_IDLE: begin
					if (head.avail)
						state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (!go_next)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Command fields held for the lookup in progress.
	always_ff @(posedge clk) begin
		if (pop) begin
			is_write_q <= head.cmd.is_write;
			crosses_q <= head.cmd.crosses;
			line_q <= head.cmd.line;
			second_q <= 1'b0;
		end else if (go_next) begin
			line_q <= line_q + 1'b1;
			second_q <= 1'b1;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (state_q == ST_CMP) begin
			hit <= found;
			way <= res_way;
			set_index <= cur_set;
			allocated <= we;
			line_number <= line_q;
			last <= !go_next;
		end
	end

endmodule

FILE: design/set_assoc_cache_directory.sv
// Top level of the set-associative cache tag directory.
//
// Usage: an access (mode, address, length) is taken at a rising edge where start
// is high and busy is low. The front end classifies whether the bytes cross the
// line end and places the access in a two-entry command queue; busy is high only
// while that queue is full.
// The back end reads one set row from the tag memory per lookup and compares it
// in the following cycle, where it also allocates and registers the result. A
// read or write hit that crosses into the next line issues the next line's read
// during that compare and then compares that line too. The back end takes a new
// access from the queue only while idle, so lookups of accesses do not overlap.
// An accepted access passes from the queue to the row read register and then
// through the compare to the result register. Each result is on the result
// ports for one cycle with valid high; last marks the final beat of an access.
// The receiver cannot stall, so results are never held back.
// Reset clears the queue, the sequencer and a per-set written flag, so every way
// reads as invalid afterward; no clearing pass is needed before the first access.
module set_assoc_cache_directory
	import scd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic mode,
	input  logic [ADDR_W-1:0] address,
	input  logic [LEN_W-1:0] length,
	output logic valid,
	output logic hit,
	output logic [WAY_W-1:0] way,
	output logic [SET_W-1:0] set_index,
	output logic allocated,
	output logic [LINE_W-1:0] line_number,
	output logic last
);

	queue_head_t head;
	logic pop;

	scd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.mode    (mode),
		.address (address),
		.length  (length),
		.head    (head),
		.pop     (pop)
	);

	scd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.pop         (pop),
		.valid       (valid),
		.hit         (hit),
		.way         (way),
		.set_index   (set_index),
		.allocated   (allocated),
		.line_number (line_number),
		.last        (last)
	);

endmodule

FILE: tb/cache_directory_checker.sv
// Shared testbench types and a checker that predicts and compares the directory results.
package dir_tb_pkg;

	import scd_pkg::*;

	// Access direction on the mode input.
	localparam logic MODE_READ = 1'b0;
	localparam logic MODE_WRITE = 1'b1;

	// One result beat as it appears on the result ports.
	typedef struct packed {
		logic hit;
		logic [WAY_W-1:0] way;
		logic [SET_W-1:0] set_index;
		logic allocated;
		logic [LINE_W-1:0] line_number;
		logic last;
	} dir_beat_t;

endpackage

module cache_directory_checker
	import scd_pkg::*;
	import dir_tb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  logic mode,
	input  logic [ADDR_W-1:0] address,
	input  logic [LEN_W-1:0] length,
	input  logic valid,
	input  logic hit,
	input  logic [WAY_W-1:0] way,
	input  logic [SET_W-1:0] set_index,
	input  logic allocated,
	input  logic [LINE_W-1:0] line_number,
	input  logic last,
	output int mismatches,
	output int outstanding,
	output int beats_checked,
	output int hit_beats,
	output int fill_beats,
	output int split_accesses
);

	timeunit 1ns;
	timeprecision 1ps;

	// Mirror of the directory: a tag and a valid flag per way of every set.
	logic [TAG_W-1:0] tag_mirror [SETS][WAYS];
	logic [WAYS-1:0] valid_mirror [SETS];

	// Predicted beats in the order the block must deliver them.
	dir_beat_t lookups_due [$];

	// Look one line up in the mirror, allocating on a miss when fill is set.
	task automatic resolve_line(input logic [LINE_W-1:0] line, input logic fill,
			input logic final_beat, output dir_beat_t beat);
		logic [SET_W-1:0] set_sel;
		logic [TAG_W-1:0] tag_val;
		logic free_found;
		int w;
		set_sel = line[SET_W-1:0];
		tag_val = line[LINE_W-1:SET_W];
		beat = '0;
		beat.set_index = set_sel;
		beat.line_number = line;
		beat.last = final_beat;
		// The lowest valid way with a matching tag wins.
		for (w = 0; w < WAYS; w++) begin
			if (!beat.hit && valid_mirror[set_sel][w] && tag_mirror[set_sel][w] == tag_val) begin
				beat.hit = 1'b1;
				beat.way = WAY_W'(w);
			end
		end
		// A read miss fills the first invalid way, or way 0 when the set is full.
		if (!beat.hit && fill) begin
			free_found = 1'b0;
			for (w = 0; w < WAYS; w++) begin
				if (!free_found && !valid_mirror[set_sel][w]) begin
					free_found = 1'b1;
					beat.way = WAY_W'(w);
				end
			end
			valid_mirror[set_sel][beat.way] = 1'b1;
			tag_mirror[set_sel][beat.way] = tag_val;
			beat.allocated = 1'b1;
		end
	endtask

	// Work out the one or two beats of an accepted access.
	task automatic resolve_access(input logic acc_mode, input logic [ADDR_W-1:0] addr,
			input logic [LEN_W-1:0] len);
		logic [LINE_W-1:0] line;
		logic crosses;
		logic fill;
		dir_beat_t first_beat;
		dir_beat_t next_beat;
		line = addr[ADDR_W-1:OFF_W];
		crosses = (int'(addr[OFF_W-1:0]) + int'(len)) > LINE_BYTES;
		fill = (acc_mode == MODE_READ);
		resolve_line(line, fill, !crosses, first_beat);
		// A miss that crosses the line end reports only the first line.
		if (crosses && !first_beat.hit)
			first_beat.last = 1'b1;
		lookups_due.push_back(first_beat);
		// A crossing hit also looks up the next line, wrapping past the top of memory.
		if (crosses && first_beat.hit) begin
			line = line + 1'b1;
			resolve_line(line, fill, 1'b1, next_beat);
			lookups_due.push_back(next_beat);
			split_accesses++;
		end
	endtask

	// Report one field that differs from its prediction.
	task automatic compare_field(input string name, input logic [LINE_W-1:0] want,
			input logic [LINE_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	// Compare the beat on the result ports first, then predict any newly accepted access.
	always @(posedge clk) begin
		dir_beat_t want;
		if (!arst_n) begin
			foreach (valid_mirror[s])
				valid_mirror[s] = '0;
			lookups_due.delete();
		end else begin
			if (valid === 1'b1) begin
				beats_checked++;
				if (lookups_due.size() == 0) begin
					$error("unexpected result beat for line 0x%0h", line_number);
					mismatches++;
				end else begin
					want = lookups_due.pop_front();
					compare_field("hit", want.hit, hit);
					compare_field("way", want.way, way);
					compare_field("set_index", want.set_index, set_index);
					compare_field("allocated", want.allocated, allocated);
					compare_field("line_number", want.line_number, line_number);
					compare_field("last", want.last, last);
					if (want.hit)
						hit_beats++;
					if (want.allocated)
						fill_beats++;
				end
			end else if (valid !== 1'b0) begin
				$error("valid: expected 0 or 1, got %b", valid);
				mismatches++;
			end
			if (start === 1'b1 && busy === 1'b0)
				resolve_access(mode, address, length);
		end
		outstanding <= lookups_due.size();
	end

endmodule

FILE: tb/testbench.sv
// Testbench top: clock, reset, access stimulus and the final verdict for the cache directory.
module testbench
	import scd_pkg::*;
	import dir_tb_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ACCESSES = 1750;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 16;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic mode;
	logic [ADDR_W-1:0] address;
	logic [LEN_W-1:0] length;
	logic valid;
	logic hit;
	logic [WAY_W-1:0] way;
	logic [SET_W-1:0] set_index;
	logic allocated;
	logic [LINE_W-1:0] line_number;
	logic last;

	int mismatches;
	int outstanding;
	int beats_checked;
	int hit_beats;
	int fill_beats;
	int split_accesses;
	int cycle_count;
	int burst_left;
	int reads_sent;
	int writes_sent;

	set_assoc_cache_directory dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.address(address),
		.length(length),
		.valid(valid),
		.hit(hit),
		.way(way),
		.set_index(set_index),
		.allocated(allocated),
		.line_number(line_number),
		.last(last)
	);

	cache_directory_checker checker_inst (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.address(address),
		.length(length),
		.valid(valid),
		.hit(hit),
		.way(way),
		.set_index(set_index),
		.allocated(allocated),
		.line_number(line_number),
		.last(last),
		.mismatches(mismatches),
		.outstanding(outstanding),
		.beats_checked(beats_checked),
		.hit_beats(hit_beats),
		.fill_beats(fill_beats),
		.split_accesses(split_accesses)
	);

	// Free-running clock.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Cycle counter for the watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Watchdog: the run must end well before the limit.
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Verification failed");
		$finish;
	end

	// Drive one access beat, opening a new burst after a random gap when the last one ran out.
	task automatic send_access(input logic acc_mode, input logic [ADDR_W-1:0] addr,
			input logic [LEN_W-1:0] len);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = $urandom_range(0, 8);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		start <= 1'b1;
		mode <= acc_mode;
		address <= addr;
		length <= len;
		do @(posedge clk); while (busy !== 1'b0);
		if (acc_mode == MODE_READ)
			reads_sent++;
		else
			writes_sent++;
	endtask

	// Hot sets where random accesses pile up to force hits and evictions.
	logic [SET_W-1:0] hot_sets [6] = '{7'd0, 7'd1, 7'd5, 7'd63, 7'd126, 7'd127};

	initial begin
		logic [TAG_W-1:0] tag_val;
		logic [SET_W-1:0] set_sel;
		logic [OFF_W-1:0] offset;
		logic [ADDR_W-1:0] addr;
		logic [LEN_W-1:0] len;
		logic acc_mode;
		int kind;
		int t;
		int n;

		arst_n = 1'b0;
		start = 1'b0;
		mode = MODE_READ;
		address = '0;
		length = 3'd1;
		burst_left = 0;
		reads_sent = 0;
		writes_sent = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: first fill and hit, write miss and write hit.
		send_access(MODE_READ, 32'h0000_0000, 3'd1);
		send_access(MODE_READ, 32'h0000_0000, 3'd1);
		send_access(MODE_WRITE, 32'h0000_0040, 3'd4);
		send_access(MODE_WRITE, 32'h0000_0000, 3'd2);
		// Crossing read hit whose next line misses and is filled.
		send_access(MODE_READ, 32'h0000_003e, 3'd4);
		// Crossing write hit whose next line misses without a fill.
		send_access(MODE_WRITE, 32'h0000_007f, 3'd2);
		// Crossing read miss: only the first line is filled and reported.
		send_access(MODE_READ, 32'h0000_00bf, 3'd4);
		// Top line of memory, then crossings that wrap to line zero.
		send_access(MODE_READ, 32'hffff_ffff, 3'd1);
		send_access(MODE_READ, 32'hffff_fffd, 3'd4);
		send_access(MODE_WRITE, 32'hffff_ffff, 3'd2);
		// Lengths outside one to four: zero never crosses, larger ones count as given.
		send_access(MODE_READ, 32'h0000_003f, 3'd0);
		send_access(MODE_READ, 32'h0000_003c, 3'd5);
		send_access(MODE_WRITE, 32'h0000_0039, 3'd7);
		send_access(MODE_READ, 32'h0000_003a, 3'd7);
		// Fill all ways of one set, then evict way 0 and refetch the evicted line.
		for (t = 1; t <= WAYS + 1; t++) begin
			tag_val = TAG_W'(t);
			send_access(MODE_READ, {tag_val, 7'd5, 6'd0}, 3'd1);
		end
		send_access(MODE_READ, {19'd1, 7'd5, 6'd0}, 3'd3);
		send_access(MODE_WRITE, {19'd2, 7'd5, 6'd63}, 3'd4);

		// Random: mostly clustered accesses, mixed with wide addresses and the top of memory.
		for (n = 0; n < RANDOM_ACCESSES; n++) begin
			kind = $urandom_range(0, 99);
			if (kind < 70) begin
				tag_val = TAG_W'($urandom_range(0, 11));
				if ($urandom_range(0, 3) == 0)
					tag_val = ~tag_val;
				if ($urandom_range(0, 4) == 0)
					set_sel = SET_W'($urandom_range(0, SETS - 1));
				else
					set_sel = hot_sets[$urandom_range(0, 5)];
				if ($urandom_range(0, 1) == 0)
					offset = OFF_W'($urandom_range(0, LINE_BYTES - 1));
				else
					offset = OFF_W'($urandom_range(LINE_BYTES - 6, LINE_BYTES - 1));
				addr = {tag_val, set_sel, offset};
			end else if (kind < 85) begin
				addr = $urandom();
			end else begin
				addr = 32'hffff_ff00 | ADDR_W'($urandom_range(0, 255));
			end
			if ($urandom_range(0, 19) == 0)
				len = LEN_W'($urandom_range(0, 7));
			else
				len = LEN_W'($urandom_range(1, 4));
			acc_mode = ($urandom_range(0, 99) < 60) ? MODE_READ : MODE_WRITE;
			send_access(acc_mode, addr, len);
		end
		start <= 1'b0;

		// Let the last prediction land, wait for every beat, then watch for strays.
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d reads and %0d writes, %0d of them split across two lines.",
			reads_sent, writes_sent, split_accesses);
		$display("Checked %0d result beats: %0d hits and %0d line fills.",
			beats_checked, hit_beats, fill_beats);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: filelist.f
design/scd_pkg.sv
design/scd_front.sv
design/scd_back.sv
design/set_assoc_cache_directory.sv
tb/cache_directory_checker.sv
tb/testbench.sv
